// File: design/srr_pkg.sv
// Shared types, constants and helpers of the selective repeat receiver.
// No dependencies; every other design file but srr_slot_ram uses this package.
package srr_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int RUN_W      = $clog2(WINDOW_MAX);

  localparam int SEQ_W      = 31;
  localparam int CHK_W      = 32;
  localparam int PW_W       = 64;
  localparam int PH_W       = 32;
  localparam int WIN_W      = 5;
  localparam int BSUM_W     = 12;
  localparam int WORD_BYTES = PW_W / 8;
  localparam int HIGH_BYTES = PH_W / 8;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  localparam logic KIND_ECHO    = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOK,
    S_DECIDE,
    S_BASE,
    S_RUN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [CHK_W-1:0] chk;
    logic [PW_W-1:0]  p0;
    logic [PW_W-1:0]  p1;
    logic [PH_W-1:0]  p2;
  } pkt_t;

  typedef struct packed {
    logic             ok;
    logic             wrapped;
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
  } cls_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [PW_W-1:0]  p0;
    logic [PW_W-1:0]  p1;
    logic [PH_W-1:0]  p2;
  } slot_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [CHK_W-1:0] chk;
    logic [PW_W-1:0]  p0;
    logic [PW_W-1:0]  p1;
    logic [PH_W-1:0]  p2;
  } res_t;

  typedef struct packed {
    logic load;
    logic eval;
  } fctl_t;

  // Sum of the low nbytes bytes of w, each taken as signed.
  function automatic logic signed [BSUM_W-1:0] byte_sum(input logic [PW_W-1:0] w,
                                                        input int unsigned nbytes);
    logic signed [BSUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (i < nbytes) begin
        s = s + $signed({{(BSUM_W-8){w[8*i+7]}}, w[8*i +: 8]});
      end
    end
    return s;
  endfunction

endpackage

// File: design/srr_if.sv
// Packet and result channel interfaces of the selective repeat receiver.
// Depends on srr_pkg for field widths.
interface srr_in_if;
  logic                      valid;
  logic                      ready;
  logic [srr_pkg::SEQ_W-1:0] seq_num;
  logic [srr_pkg::SEQ_W-1:0] ack_num;
  logic [srr_pkg::CHK_W-1:0] check_word;
  logic [srr_pkg::PW_W-1:0]  payload_low;
  logic [srr_pkg::PW_W-1:0]  payload_mid;
  logic [srr_pkg::PH_W-1:0]  payload_high;

  modport source (output valid, seq_num, ack_num, check_word, payload_low, payload_mid,
                  payload_high, input ready);
  modport sink   (input valid, seq_num, ack_num, check_word, payload_low, payload_mid,
                  payload_high, output ready);
endinterface

interface srr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [srr_pkg::SEQ_W-1:0] out_seq;
  logic [srr_pkg::SEQ_W-1:0] out_ack;
  logic [srr_pkg::CHK_W-1:0] out_check;
  logic [srr_pkg::PW_W-1:0]  out_payload_low;
  logic [srr_pkg::PW_W-1:0]  out_payload_mid;
  logic [srr_pkg::PH_W-1:0]  out_payload_high;
  logic                      last;

  modport source (output valid, kind, out_seq, out_ack, out_check, out_payload_low,
                  out_payload_mid, out_payload_high, last, input ready);
  modport sink   (input valid, kind, out_seq, out_ack, out_check, out_payload_low,
                  out_payload_mid, out_payload_high, last, output ready);
endinterface

// File: design/selective_repeat_receiver.sv
// Selective repeat ARQ receiver. A packet is accepted only while the block is
// idle and goes through capture, checksum, reorder slot lookup and classification;
// each result it causes then passes through the output register. A run of buffered
// in-order packets drains one per cycle while the consumer keeps up, thanks to a
// read-ahead on the slot RAM port. Input stays blocked until the final result (last
// set) has entered the output register, which can still be waiting on the consumer
// when the next packet is taken. Packets with a bad checksum or outside the window
// give no result. Slot occupancy is kept in flip-flops, so no clearing pass runs
// after reset. The user must write the receive window through cfg_we and cfg_wdata
// only while idle; the block does not enforce this. Values above the buffer depth
// act as the buffer depth.
// Depends on srr_pkg, srr_if, srr_slot_ram, srr_front and srr_ctrl.
module selective_repeat_receiver (
  input  logic                      clk,
  input  logic                      rst_n,
  srr_in_if.sink                    in_ch,
  srr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [srr_pkg::WIN_W-1:0] cfg_wdata
);
  import srr_pkg::*;

  pkt_t             pkt_in;
  pkt_t             pkt;
  cls_t             cls;
  fctl_t            fctl;
  logic [SEQ_W-1:0] base;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             ram_we;
  slot_t            rd_data;
  slot_t            wr_data;
  res_t             out_res;
  logic             out_last;

  assign pkt_in = '{seq: in_ch.seq_num, ack: in_ch.ack_num, chk: in_ch.check_word,
                    p0: in_ch.payload_low, p1: in_ch.payload_mid, p2: in_ch.payload_high};

  srr_front u_front (
    .clk    (clk),
    .fctl   (fctl),
    .pkt_in (pkt_in),
    .base   (base),
    .pkt    (pkt),
    .cls    (cls)
  );

  srr_slot_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH ($bits(slot_t))
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fctl      (fctl),
    .base      (base),
    .pkt       (pkt),
    .cls       (cls),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ram_we    (ram_we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign out_ch.kind             = out_res.kind;
  assign out_ch.out_seq          = out_res.seq;
  assign out_ch.out_ack          = out_res.ack;
  assign out_ch.out_check        = out_res.chk;
  assign out_ch.out_payload_low  = out_res.p0;
  assign out_ch.out_payload_mid  = out_res.p1;
  assign out_ch.out_payload_high = out_res.p2;
  assign out_ch.last             = out_last;

endmodule

// File: design/srr_slot_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies; holds the reorder buffer slots.
module srr_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/srr_front.sv
// Packet capture, checksum test and window distance computation.
// Depends on srr_pkg; driven by srr_ctrl through an fctl_t strobe pair.
module srr_front (
  input  logic                      clk,
  input  srr_pkg::fctl_t            fctl,
  input  srr_pkg::pkt_t             pkt_in,
  input  logic [srr_pkg::SEQ_W-1:0] base,
  output srr_pkg::pkt_t             pkt,
  output srr_pkg::cls_t             cls
);
  import srr_pkg::*;

  pkt_t                     pkt_r;
  cls_t                     cls_r;
  logic signed [BSUM_W-1:0] s0_r;
  logic signed [BSUM_W-1:0] s1_r;
  logic signed [BSUM_W-1:0] s2_r;
  logic [CHK_W-1:0]         total;

  // Byte sums are taken at capture; the wide add and compare happen on the eval strobe.
  always_ff @(posedge clk) begin
    if (fctl.load) begin
      pkt_r <= pkt_in;
      s0_r  <= byte_sum(pkt_in.p0, WORD_BYTES);
      s1_r  <= byte_sum(pkt_in.p1, WORD_BYTES);
      s2_r  <= byte_sum({{(PW_W-PH_W){1'b0}}, pkt_in.p2}, HIGH_BYTES);
    end
    if (fctl.eval) begin
      cls_r <= '{ok:      (total == '1),
                 wrapped: (pkt_r.seq < base),
                 ahead:   pkt_r.seq - base,
                 behind:  base - pkt_r.seq};
    end
  end

  assign total = {1'b0, pkt_r.seq} + {1'b0, pkt_r.ack} + pkt_r.chk
               + {{(CHK_W-BSUM_W){s0_r[BSUM_W-1]}}, s0_r}
               + {{(CHK_W-BSUM_W){s1_r[BSUM_W-1]}}, s1_r}
               + {{(CHK_W-BSUM_W){s2_r[BSUM_W-1]}}, s2_r};

  assign pkt = pkt_r;
  assign cls = cls_r;

endmodule

// File: design/srr_ctrl.sv
// Sequencer: slot lookup, buffer update, delivery run and the result register.
// Depends on srr_pkg; talks to srr_front and srr_slot_ram.
module srr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output srr_pkg::res_t             out_res,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [srr_pkg::WIN_W-1:0] cfg_wdata,
  output srr_pkg::fctl_t            fctl,
  output logic [srr_pkg::SEQ_W-1:0] base,
  input  srr_pkg::pkt_t             pkt,
  input  srr_pkg::cls_t             cls,
  output logic [srr_pkg::IDX_W-1:0] rd_addr,
  input  srr_pkg::slot_t            rd_data,
  output logic                      ram_we,
  output logic [srr_pkg::IDX_W-1:0] wr_addr,
  output srr_pkg::slot_t            wr_data
);
  import srr_pkg::*;

  localparam logic [SEQ_W-1:0] SEQ_MAX        = '1;
  localparam logic [SEQ_W-1:0] BASE_RESET     = SEQ_W'(1);
  localparam logic [IDX_W-1:0] BASE_IDX_RESET = IDX_W'(1 % WINDOW_MAX);
  localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(WINDOW_MAX - 1);
  localparam logic [RUN_W-1:0] RUN_LAST       = RUN_W'(WINDOW_MAX - 1);
  localparam logic [IDX_W:0]   IDX_SPAN       = (IDX_W+1)'(WINDOW_MAX);

  // Slot of base+1, kept in step with the 2^31 wrap of the sequence space.
  function automatic logic [IDX_W-1:0] idx_step(input logic [IDX_W-1:0] idx,
                                                input logic [SEQ_W-1:0] seq);
    logic [IDX_W-1:0] r;
    if (seq == SEQ_MAX) begin
      r = '0;
    end else if (idx == IDX_LAST) begin
      r = '0;
    end else begin
      r = idx + IDX_W'(1);
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [WIN_W-1:0]    win_r;
  logic [WIN_W-1:0]    w_eff;
  logic [SEQ_W-1:0]    base_r, base_nxt;
  logic [IDX_W-1:0]    base_idx_r, base_idx_nxt;
  logic [WINDOW_MAX-1:0] valid_r;
  logic [RUN_W-1:0]    runs_r;
  logic [IDX_W-1:0]    sidx_r;
  logic [IDX_W-1:0]    sidx_calc;
  logic [IDX_W:0]      sidx_sum;
  res_t                pend_r;
  res_t                out_res_r;
  logic                out_last_r;
  logic                out_valid_r, out_valid_nxt;

  logic out_free, in_win, at_base, old_pkt, dup, hit;
  logic push, push_last, step_base, run_clr, run_inc, clr_valid;
  logic pend_echo, pend_dlv_pkt, pend_dlv_slot;

  assign w_eff    = (32'(win_r) > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : win_r;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign in_win  = cls.ok && (cls.ahead != '0) && (cls.ahead < SEQ_W'(w_eff));
  assign at_base = cls.ok && (cls.ahead == '0);
  assign old_pkt = cls.ok && (cls.behind != '0) && (cls.behind <= SEQ_W'(w_eff));

  assign dup = valid_r[sidx_r] && (rd_data.seq == pkt.seq);
  assign hit = valid_r[base_idx_r] && (rd_data.seq == base_r) && (runs_r != RUN_LAST);

  assign base_nxt     = base_r + SEQ_W'(1);
  assign base_idx_nxt = idx_step(base_idx_r, base_r);

  // In-window slot = (base slot + distance) mod WINDOW_MAX; a packet past the
  // 2^31 wrap is below WINDOW_MAX, so its own low bits are the slot.
  assign sidx_sum = {1'b0, base_idx_r} + {1'b0, cls.ahead[IDX_W-1:0]};
  always_comb begin
    if (cls.wrapped) begin
      sidx_calc = pkt.seq[IDX_W-1:0];
    end else if (sidx_sum >= IDX_SPAN) begin
      sidx_calc = IDX_W'(sidx_sum - IDX_SPAN);
    end else begin
      sidx_calc = sidx_sum[IDX_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (in_win || old_pkt) begin
          state_nxt = S_FLUSH;
        end else if (at_base) begin
          state_nxt = S_BASE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BASE:   if (out_free) state_nxt = S_RUN;
      S_RUN:    if (!hit) state_nxt = S_FLUSH;
      S_FLUSH:  if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State outputs. The result waits in pend_r until we know whether another
  // one follows, which sets its last flag.
  always_comb begin
    fctl          = '0;
    rd_addr       = base_idx_r;
    ram_we        = 1'b0;
    push          = 1'b0;
    push_last     = 1'b0;
    step_base     = 1'b0;
    run_clr       = 1'b0;
    run_inc       = 1'b0;
    clr_valid     = 1'b0;
    pend_echo     = 1'b0;
    pend_dlv_pkt  = 1'b0;
    pend_dlv_slot = 1'b0;
    unique case (state_r)
      S_IDLE:   fctl.load = in_valid;
      S_CHECK:  fctl.eval = 1'b1;
      S_LOOK:   rd_addr = sidx_calc;
      S_DECIDE: begin
        ram_we       = in_win && !dup;
        pend_echo    = in_win || old_pkt;
        pend_dlv_pkt = at_base;
      end
      S_BASE: begin
        rd_addr = base_idx_nxt;
        if (out_free) begin
          push      = 1'b1;
          pend_echo = 1'b1;
          step_base = 1'b1;
          run_clr   = 1'b1;
        end
      end
      S_RUN: begin
        // read ahead at the next base so a run moves one slot per cycle while the output is free
        if (hit && out_free) begin
          rd_addr       = base_idx_nxt;
          push          = 1'b1;
          pend_dlv_slot = 1'b1;
          clr_valid     = 1'b1;
          step_base     = 1'b1;
          run_inc       = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_RESET;
      base_r      <= BASE_RESET;
      base_idx_r  <= BASE_IDX_RESET;
      valid_r     <= '0;
      runs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      if (step_base) begin
        base_r     <= base_nxt;
        base_idx_r <= base_idx_nxt;
      end
      if (ram_we) begin
        valid_r[sidx_r] <= 1'b1;
      end
      if (clr_valid) begin
        valid_r[base_idx_r] <= 1'b0;
      end
      if (run_clr) begin
        runs_r <= '0;
      end else if (run_inc) begin
        runs_r <= runs_r + RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      sidx_r <= sidx_calc;
    end
    if (pend_echo) begin
      pend_r <= '{kind: KIND_ECHO, seq: pkt.seq, ack: pkt.ack, chk: pkt.chk,
                  p0: pkt.p0, p1: pkt.p1, p2: pkt.p2};
    end else if (pend_dlv_pkt) begin
      pend_r <= '{kind: KIND_DELIVER, seq: pkt.seq, ack: '0, chk: '0,
                  p0: pkt.p0, p1: pkt.p1, p2: pkt.p2};
    end else if (pend_dlv_slot) begin
      pend_r <= '{kind: KIND_DELIVER, seq: base_r, ack: '0, chk: '0,
                  p0: rd_data.p0, p1: rd_data.p1, p2: rd_data.p2};
    end
    if (push) begin
      out_res_r  <= pend_r;
      out_last_r <= push_last;
    end
  end

  assign wr_addr   = sidx_r;
  assign wr_data   = '{seq: pkt.seq, p0: pkt.p0, p1: pkt.p1, p2: pkt.p2};
  assign base      = base_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

// File: design/srr_checker.sv
// Port-level checks of the selective repeat receiver, bound to the top level.
// Depends on srr_pkg and selective_repeat_receiver.
module srr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_kind,
  input logic [srr_pkg::SEQ_W-1:0] out_seq,
  input logic                      out_last
);
  import srr_pkg::*;

  logic [SEQ_W-1:0] exp_dlv_r;
  logic             out_xfer;

  assign out_xfer = out_valid && out_ready;

  // Deliveries leave strictly in sequence order, starting at one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_dlv_r <= SEQ_W'(1);
    end else if (out_xfer && (out_kind == KIND_DELIVER)) begin
      exp_dlv_r <= exp_dlv_r + SEQ_W'(1);
    end
  end

  a_dlv_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (out_kind == KIND_DELIVER) |-> out_seq == exp_dlv_r)
    else $error("delivery out of sequence order");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second packet taken while one is in work");

  a_rest_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open while results of a packet are still due");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seq) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_seq   (out_ch.out_seq),
  .out_last  (out_ch.last)
);

// File: sim/tb_selective_repeat_receiver.sv
`timescale 1ns / 100ps
// Testbench of selective_repeat_receiver: a directed packet plan followed by random traffic,
// scored against a behavioral model of the receive window and the reorder buffer.
// Depends on srr_pkg, srr_if and the design sources.
module tb_selective_repeat_receiver;
  import srr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_GOAL = 182;
  localparam int PHASE_LEN   = 35;
  localparam int DRAIN_GAP   = 12;
  localparam int PLAN_LEN    = 32;

  typedef enum logic [0:0] {ROW_PKT, ROW_CFG} row_op_t;
  // WANT_MODEL rows are scored by the model; the others carry their result shape inline.
  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_ECHO, WANT_PAIR} want_t;

  typedef struct packed {
    row_op_t          op;
    want_t            want;
    logic [WIN_W-1:0] win;
    logic             bad_sum;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [PW_W-1:0]  p0;
    logic [PW_W-1:0]  p1;
    logic [PH_W-1:0]  p2;
  } plan_row_t;

  typedef struct packed {
    res_t body;
    logic last;
  } rx_result_t;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_PKT, WANT_PAIR,  5'd0, 1'b0, 31'd1, 31'd0, 64'h0, 64'h0, 32'h0},
    '{ROW_PKT, WANT_NONE,  5'd0, 1'b1, 31'd2, 31'd9, 64'h7F7F_7F7F_7F7F_7F7F,
      64'h0102_0304_0506_0708, 32'h7F80_0000},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd1, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd4, 31'd5, 64'h8080_8080_8080_8080,
      64'h8080_8080_8080_8080, 32'h8080_8080},
    // same sequence again, new payload: buffer keeps the first copy
    '{ROW_PKT, WANT_MODEL, 5'd0, 1'b0, 31'd4, 31'd6, 64'hDEAD_BEEF_0000_0004, 64'h0, 32'h0},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd3, 31'd4, 64'h3, 64'h33, 32'h3},
    '{ROW_PKT, WANT_MODEL, 5'd0, 1'b0, 31'd2, 31'd3, 64'h2, 64'h22, 32'h2},
    '{ROW_PKT, WANT_NONE,  5'd0, 1'b0, 31'd13, 31'd1, 64'h0D, 64'h0, 32'h0},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'h7FFF_FFFF, 31'd0, 64'h7F, 64'h80, 32'hFF},
    // oversized window, then fill every slot ahead of the base and release them with the base
    '{ROW_CFG, WANT_MODEL, 5'd31, 1'b0, 31'd0, 31'd0, 64'h0, 64'h0, 32'h0},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd20, 31'd20, 64'h14, 64'h1400, 32'h14},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd19, 31'd19, 64'h13, 64'h1300, 32'h13},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd18, 31'd18, 64'h12, 64'h1200, 32'h12},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd17, 31'd17, 64'h11, 64'h1100, 32'h11},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd16, 31'd16, 64'h10, 64'h1000, 32'h10},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd15, 31'd15, 64'h0F, 64'h0F00, 32'h0F},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd14, 31'd14, 64'h0E, 64'h0E00, 32'h0E},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd13, 31'd13, 64'h0D, 64'h0D00, 32'h0D},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd12, 31'd12, 64'h0C, 64'h0C00, 32'h0C},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd11, 31'd11, 64'h0B, 64'h0B00, 32'h0B},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd10, 31'd10, 64'h0A, 64'h0A00, 32'h0A},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd9, 31'd9, 64'h09, 64'h0900, 32'h09},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd8, 31'd8, 64'h08, 64'h0800, 32'h08},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd7, 31'd7, 64'h07, 64'h0700, 32'h07},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd6, 31'd6, 64'h06, 64'h0600, 32'h06},
    '{ROW_PKT, WANT_MODEL, 5'd0, 1'b0, 31'd5, 31'd5, 64'h05, 64'h0500, 32'h05},
    // zero window: only the base gets through
    '{ROW_CFG, WANT_MODEL, 5'd0, 1'b0, 31'd0, 31'd0, 64'h0, 64'h0, 32'h0},
    '{ROW_PKT, WANT_NONE,  5'd0, 1'b0, 31'd22, 31'd2, 64'h16, 64'h0, 32'h0},
    '{ROW_PKT, WANT_PAIR,  5'd0, 1'b0, 31'd21, 31'd3, 64'h15, 64'h15, 32'h15},
    '{ROW_CFG, WANT_MODEL, 5'd1, 1'b0, 31'd0, 31'd0, 64'h0, 64'h0, 32'h0},
    '{ROW_PKT, WANT_ECHO,  5'd0, 1'b0, 31'd21, 31'd4, 64'h15, 64'h0, 32'h1},
    '{ROW_PKT, WANT_NONE,  5'd0, 1'b0, 31'd23, 31'd5, 64'h17, 64'h0, 32'h0}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  srr_in_if  in_ch ();
  srr_out_if out_ch ();

  selective_repeat_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // model state
  logic [WIN_W-1:0] window_copy;
  logic [SEQ_W-1:0] next_base;
  logic             slot_full [WINDOW_MAX];
  slot_t            slot_data [WINDOW_MAX];
  rx_result_t       due_results [$];

  int          mismatches = 0;
  int unsigned cycles     = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_selective_repeat_receiver failed");
      $finish;
    end
  end

  // one quarter of the time (cycles[10:9] == 2'b01) runs with no idling on either side
  function automatic bit take_break();
    return (cycles[10:9] != 2'b01) && ($urandom_range(99) < 12);
  endfunction

  function automatic int unsigned window_now();
    return (window_copy > WINDOW_MAX) ? WINDOW_MAX : window_copy;
  endfunction

  function automatic logic [31:0] signed_bytes(input logic [PW_W-1:0] w, input int count);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < count; i++) s = s + {{24{w[8*i+7]}}, w[8*i +: 8]};
    return s;
  endfunction

  function automatic logic [31:0] header_sum(input pkt_t p);
    return 32'(p.seq) + 32'(p.ack) + p.chk + signed_bytes(p.p0, 8) + signed_bytes(p.p1, 8)
           + signed_bytes(64'(p.p2), 4);
  endfunction

  function automatic pkt_t seal(input pkt_t p, input logic spoil);
    int b;
    p.chk = '0;
    p.chk = ~header_sum(p);
    if (spoil) begin
      b = $urandom_range(CHK_W - 1);
      p.chk[b] = ~p.chk[b];
    end
    return p;
  endfunction

  function automatic void owe(input logic kind, input logic [SEQ_W-1:0] seq,
                              input logic [SEQ_W-1:0] ack, input logic [CHK_W-1:0] chk,
                              input logic [PW_W-1:0] p0, input logic [PW_W-1:0] p1,
                              input logic [PH_W-1:0] p2, input logic last);
    rx_result_t r;
    r.body = '{kind: kind, seq: seq, ack: ack, chk: chk, p0: p0, p1: p1, p2: p2};
    r.last = last;
    due_results.insert(due_results.size(), r);
  endfunction

  // Updates the window state for one accepted packet and queues the results it causes.
  function automatic int receive_packet(input pkt_t p);
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
    logic [IDX_W-1:0] idx;
    int unsigned      w;
    int               n;
    if (header_sum(p) != 32'hFFFF_FFFF) return 0;
    w      = window_now();
    ahead  = p.seq - next_base;
    behind = next_base - p.seq;
    n      = 0;
    if (ahead >= 1 && ahead < w) begin
      idx = IDX_W'(p.seq % WINDOW_MAX);
      if (!(slot_full[idx] && slot_data[idx].seq == p.seq)) begin
        slot_full[idx] = 1'b1;
        slot_data[idx] = '{seq: p.seq, p0: p.p0, p1: p.p1, p2: p.p2};
      end
      owe(KIND_ECHO, p.seq, p.ack, p.chk, p.p0, p.p1, p.p2, 1'b0);
      n = 1;
    end else if (ahead == 0) begin
      owe(KIND_DELIVER, p.seq, '0, '0, p.p0, p.p1, p.p2, 1'b0);
      owe(KIND_ECHO, p.seq, p.ack, p.chk, p.p0, p.p1, p.p2, 1'b0);
      n = 2;
      next_base = next_base + 1'b1;
      // at most WINDOW_MAX-1 buffered deliveries follow the pair
      while (n < WINDOW_MAX + 1) begin
        idx = IDX_W'(next_base % WINDOW_MAX);
        if (!(slot_full[idx] && slot_data[idx].seq == next_base)) break;
        owe(KIND_DELIVER, next_base, '0, '0, slot_data[idx].p0, slot_data[idx].p1,
            slot_data[idx].p2, 1'b0);
        slot_full[idx] = 1'b0;
        next_base = next_base + 1'b1;
        n++;
      end
    end else if (behind >= 1 && behind <= w) begin
      owe(KIND_ECHO, p.seq, p.ack, p.chk, p.p0, p.p1, p.p2, 1'b0);
      n = 1;
    end
    if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
    return n;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_packet(input pkt_t p, input want_t want);
    int n;
    while (take_break()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.seq_num      = p.seq;
    in_ch.ack_num      = p.ack;
    in_ch.check_word   = p.chk;
    in_ch.payload_low  = p.p0;
    in_ch.payload_mid  = p.p1;
    in_ch.payload_high = p.p2;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n = receive_packet(p);
    if (want != WANT_MODEL) begin
      repeat (n) void'(due_results.pop_back());
      if (want == WANT_PAIR) owe(KIND_DELIVER, p.seq, '0, '0, p.p0, p.p1, p.p2, 1'b0);
      if (want != WANT_NONE) owe(KIND_ECHO, p.seq, p.ack, p.chk, p.p0, p.p1, p.p2, 1'b1);
    end
    @(negedge clk);
  endtask

  // Dropped packets give no result, so leave time for the pipeline to empty too.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    window_copy = value;
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rx_result_t seen;
    rx_result_t owed;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.body = '{kind: out_ch.kind, seq: out_ch.out_seq, ack: out_ch.out_ack,
                    chk: out_ch.out_check, p0: out_ch.out_payload_low,
                    p1: out_ch.out_payload_mid, p2: out_ch.out_payload_high};
      seen.last = out_ch.last;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got seq %h kind %b", $time,
                 seen.body.seq, seen.body.kind);
        mismatches++;
      end else begin
        owed = due_results.pop_front();
        if (seen.body.kind !== owed.body.kind) note_mismatch("kind", owed.body.kind, seen.body.kind);
        if (seen.body.seq !== owed.body.seq) note_mismatch("out_seq", owed.body.seq, seen.body.seq);
        if (seen.body.ack !== owed.body.ack) note_mismatch("out_ack", owed.body.ack, seen.body.ack);
        if (seen.body.chk !== owed.body.chk)
          note_mismatch("out_check", owed.body.chk, seen.body.chk);
        if (seen.body.p0 !== owed.body.p0)
          note_mismatch("out_payload_low", owed.body.p0, seen.body.p0);
        if (seen.body.p1 !== owed.body.p1)
          note_mismatch("out_payload_mid", owed.body.p1, seen.body.p1);
        if (seen.body.p2 !== owed.body.p2)
          note_mismatch("out_payload_high", owed.body.p2, seen.body.p2);
        if (seen.last !== owed.last) note_mismatch("last", owed.last, seen.last);
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !take_break();
    end
  end

  initial begin
    plan_row_t   row;
    pkt_t        p;
    int          since_cfg;
    int          roll;
    int unsigned w;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.seq_num      = '0;
    in_ch.ack_num      = '0;
    in_ch.check_word   = '0;
    in_ch.payload_low  = '0;
    in_ch.payload_mid  = '0;
    in_ch.payload_high = '0;
    window_copy        = WIN_RESET;
    next_base          = SEQ_W'(1);
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.op == ROW_CFG) begin
        write_window(row.win);
      end else begin
        p = '{seq: row.seq, ack: row.ack, chk: '0, p0: row.p0, p1: row.p1, p2: row.p2};
        send_packet(seal(p, row.bad_sum), row.want);
      end
    end

    // Mostly in-window traffic around the base so the buffer fills and drains;
    // the rest lands behind the base, far ahead or anywhere, and some carry a broken checksum.
    since_cfg = PHASE_LEN;
    for (int k = 0; k < RANDOM_GOAL; k++) begin
      if (since_cfg >= PHASE_LEN) begin
        write_window(($urandom_range(99) < 35) ? WIN_W'(WINDOW_MAX) : WIN_W'($urandom_range(31)));
        since_cfg = 0;
      end
      w     = window_now();
      roll  = $urandom_range(99);
      p.ack = SEQ_W'($urandom);
      p.p0  = {$urandom, $urandom};
      p.p1  = {$urandom, $urandom};
      p.p2  = $urandom;
      if (roll < 25 || (roll < 60 && w < 2)) p.seq = next_base;
      else if (roll < 60) p.seq = next_base + SEQ_W'($urandom_range(w - 1, 1));
      else if (roll < 74 && w > 0) p.seq = next_base - SEQ_W'($urandom_range(w, 1));
      else if (roll < 86) p.seq = next_base + SEQ_W'(w + $urandom_range(20));
      else p.seq = SEQ_W'($urandom);
      send_packet(seal(p, $urandom_range(9) == 0), WANT_MODEL);
      since_cfg++;
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_selective_repeat_receiver passed");
    end else begin
      $display("tb_selective_repeat_receiver failed");
    end
    $finish;
  end

endmodule
